[sv/single_wire_servo_frame_transceiver_assert.svh]
// Assertion macros shared by the transceiver modules
`ifndef SINGLE_WIRE_SERVO_FRAME_TRANSCEIVER_ASSERT_SVH
`define SINGLE_WIRE_SERVO_FRAME_TRANSCEIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SWSFT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define SWSFT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[sv/swsft_pkg.sv]
// Types and constants of the single-wire servo frame transceiver
`timescale 1ns / 1ps

package swsft_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_BYTES  = 4;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [7:0]  HEADER_BYTE = 8'hFF;
    localparam logic [7:0]  CSUM_MASK   = 8'hF0;
    localparam logic [3:0]  LAST_BIT    = 4'd10;
    localparam logic [3:0]  REPLY_LAST  = 4'd7;

    localparam logic [CFG_W-1:0] RST_BIT_TICKS  = 16'd417;
    localparam logic [CFG_W-1:0] RST_ONE_THRESH = 16'd400;
    localparam logic [CFG_W-1:0] RST_TIMEOUT    = 16'd2500;
    localparam logic [CFG_W-1:0] RST_TURNAROUND = 16'd1000;
    localparam logic [CFG_W-1:0] RST_GAP        = 16'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_TICKS  = 3'd0,
        CFG_ONE_THRESH = 3'd1,
        CFG_TIMEOUT    = 3'd2,
        CFG_TURNAROUND = 3'd3,
        CFG_GAP        = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TX   = 3'd1,
        PH_TURN = 3'd2,
        PH_ARM  = 3'd3,
        PH_HIGH = 3'd4,
        PH_MEAS = 3'd5,
        PH_GAP  = 3'd6
    } t_phase;

    // classified beat as it waits in the queue
    typedef struct packed {
        logic                      kind;
        logic                      line;
        logic [IN_BYTES-1:0][7:0]  data;
        logic [7:0]                csum;
    } t_item;

    typedef struct packed {
        logic       line_out;
        logic       line_drive;
        logic       busy_res;
        logic       reply_valid;
        logic [7:0] reply_byte;
    } t_result;

endpackage

[sv/swsft_in_if.sv]
// Input channel of the transceiver: valid/ready plus the item fields
`timescale 1ns / 1ps

interface swsft_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [7:0] data3;
    logic [1:0] position;
    logic       line_in;

    modport source (
        output valid, kind, data0, data1, data2, data3, position, line_in,
        input  ready
    );
    modport sink (
        input  valid, kind, data0, data1, data2, data3, position, line_in,
        output ready
    );
endinterface

[sv/swsft_out_if.sv]
// Result channel of the transceiver: valid/ready plus the result fields
`timescale 1ns / 1ps

interface swsft_out_if;
    logic       valid;
    logic       ready;
    logic       line_out;
    logic       line_drive;
    logic       busy_res;
    logic       reply_valid;
    logic [7:0] reply_byte;

    modport source (
        output valid, line_out, line_drive, busy_res, reply_valid, reply_byte,
        input  ready
    );
    modport sink (
        input  valid, line_out, line_drive, busy_res, reply_valid, reply_byte,
        output ready
    );
endinterface

[sv/swsft_front.sv]
// Front end: accepts beats, works out the frame checksum, queues them
`timescale 1ns / 1ps
`include "single_wire_servo_frame_transceiver_assert.svh"

module swsft_front #(
    parameter int DATA_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    swsft_in_if.sink          i_req,
    input  logic              i_pop,
    output swsft_pkg::t_item  o_head,
    output logic              o_head_valid
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    swsft_pkg::t_item r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;

    logic             w_push;
    logic [9:0]       w_sum;
    logic [9:0]       w_fold;
    logic [7:0]       w_spread;
    swsft_pkg::t_item w_item;

    assign i_req.ready  = (r_count != CNT_W'(Q_DEPTH));
    assign w_push       = i_req.valid && i_req.ready;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_count != '0);

    // checksum: byte sum, fold the carry bits, add itself shifted up a nibble; high nibble kept, position in bits 1:0
    always_comb begin
        w_item.kind = i_req.kind;
        w_item.line = i_req.line_in;
        w_item.data = {i_req.data3, i_req.data2, i_req.data1, i_req.data0};
        w_sum = '0;
        for (int i = 0; i < swsft_pkg::IN_BYTES; i++) begin
            if (i < DATA_BYTES) begin
                w_sum = w_sum + {2'b00, w_item.data[i]};
            end
        end
        w_fold      = w_sum + (w_sum >> 8);
        w_spread    = w_fold[7:0] + {w_fold[3:0], 4'b0000};
        w_item.csum = (w_spread & swsft_pkg::CSUM_MASK) | {6'd0, i_req.position};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!w_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    `SWSFT_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `SWSFT_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(Q_DEPTH))
    `SWSFT_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, w_push && !i_pop, r_count != '0)

endmodule

[sv/swsft_back.sv]
// Back end: wire sequencer for sending, pulse timing and reply gathering
`timescale 1ns / 1ps
`include "single_wire_servo_frame_transceiver_assert.svh"

module swsft_back #(
    parameter int COUNT_WIDTH = 16,
    parameter int DATA_BYTES  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swsft_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [swsft_pkg::CFG_W-1:0]         i_cfg_data,
    input  swsft_pkg::t_item                    i_head,
    input  logic                                i_head_valid,
    output logic                                o_pop,
    swsft_out_if.source                         o_rsp
);

    localparam int CW        = COUNT_WIDTH;
    localparam int WW        = (CW > swsft_pkg::CFG_W) ? CW : swsft_pkg::CFG_W;
    localparam int FRAME_LEN = DATA_BYTES + 2;
    localparam int BIW       = $clog2(FRAME_LEN);

    // limit a 16-bit setting to what the counters can reach
    function automatic logic [CW-1:0] clip(input logic [swsft_pkg::CFG_W-1:0] v);
        logic [WW-1:0] ve;
        logic [WW-1:0] cmax;
        ve   = WW'(v);
        cmax = WW'({CW{1'b1}});
        return (ve > cmax) ? cmax[CW-1:0] : ve[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] inc(input logic [CW-1:0] v);
        return (v == {CW{1'b1}}) ? v : v + CW'(1);
    endfunction

    logic [swsft_pkg::CFG_W-1:0] r_bit_ticks, r_one_thresh, r_timeout, r_turnaround, r_gap;

    swsft_pkg::t_phase r_phase, n_phase;
    logic [BIW-1:0]    r_byte, n_byte;
    logic [3:0]        r_bit, n_bit;
    logic [CW-1:0]     r_tick, n_tick;
    logic [CW-1:0]     r_pw, n_pw;
    logic [CW-1:0]     r_wait, n_wait;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_frame [FRAME_LEN];

    logic                r_ovalid;
    swsft_pkg::t_result  r_res;

    logic [7:0]          w_fill [FRAME_LEN];
    logic                w_pop;
    logic                w_load;
    logic                w_enter_rx;
    logic                w_resolve;
    logic                w_bitval;
    logic [7:0]          w_byte;
    logic                w_tx_lvl;
    logic [CW-1:0]       w_tick_inc, w_wait_inc;
    logic [CW-1:0]       w_bit_lim, w_turn_lim, w_to_lim, w_gap_lim;
    logic [7:0]          w_shift_new;
    swsft_pkg::t_result  w_res;

    for (genvar g = 0; g < FRAME_LEN; g++) begin : g_fill
        if (g == 0) begin : g_hdr
            assign w_fill[g] = swsft_pkg::HEADER_BYTE;
        end else if (g == FRAME_LEN - 1) begin : g_csum
            assign w_fill[g] = i_head.csum;
        end else if (g <= swsft_pkg::IN_BYTES) begin : g_data
            assign w_fill[g] = i_head.data[g-1];
        end else begin : g_zero
            assign w_fill[g] = 8'd0;
        end
    end

    assign w_pop = i_head_valid && (!r_ovalid || o_rsp.ready);
    assign o_pop = w_pop;

    assign w_tick_inc = inc(r_tick);
    assign w_wait_inc = inc(r_wait);
    assign w_bit_lim  = clip((r_bit_ticks == '0) ? swsft_pkg::CFG_W'(1) : r_bit_ticks);
    assign w_turn_lim = clip(r_turnaround);
    assign w_to_lim   = clip(r_timeout);
    assign w_gap_lim  = clip(r_gap);

    // level on the wire: start bit low, data LSB first, stop bits high
    always_comb begin
        w_byte = r_frame[r_byte];
        if (r_bit == 4'd0) begin
            w_tx_lvl = 1'b0;
        end else if (r_bit <= 4'd8) begin
            w_tx_lvl = w_byte[3'(r_bit - 4'd1)];
        end else begin
            w_tx_lvl = 1'b1;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_byte      = r_byte;
        n_bit       = r_bit;
        n_tick      = r_tick;
        n_pw        = r_pw;
        n_wait      = r_wait;
        n_shift     = r_shift;
        w_res       = '0;
        w_load      = 1'b0;
        w_enter_rx  = 1'b0;
        w_resolve   = 1'b0;
        w_bitval    = 1'b0;
        w_shift_new = r_shift;

        if (i_head.kind == swsft_pkg::KIND_START) begin
            // start while busy is dropped; the wire keeps its current level
            if (r_phase == swsft_pkg::PH_IDLE) begin
                w_load           = 1'b1;
                n_byte           = '0;
                n_bit            = '0;
                n_tick           = '0;
                n_phase          = swsft_pkg::PH_TX;
                w_res.line_drive = 1'b1;
            end else if (r_phase == swsft_pkg::PH_TX) begin
                w_res.line_drive = 1'b1;
                w_res.line_out   = w_tx_lvl;
            end
        end else begin
            case (r_phase)
                swsft_pkg::PH_IDLE: begin
                end
                swsft_pkg::PH_TX: begin
                    w_res.line_drive = 1'b1;
                    w_res.line_out   = w_tx_lvl;
                    n_tick           = w_tick_inc;
                    if (w_tick_inc >= w_bit_lim) begin
                        n_tick = '0;
                        if (r_bit == swsft_pkg::LAST_BIT) begin
                            n_bit = '0;
                            if (r_byte == BIW'(FRAME_LEN - 1)) begin
                                if (w_turn_lim == '0) begin
                                    w_enter_rx = 1'b1;
                                end else begin
                                    n_phase = swsft_pkg::PH_TURN;
                                end
                            end else begin
                                n_byte = r_byte + BIW'(1);
                            end
                        end else begin
                            n_bit = r_bit + 4'd1;
                        end
                    end
                end
                swsft_pkg::PH_TURN: begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= w_turn_lim) begin
                        w_enter_rx = 1'b1;
                    end
                end
                swsft_pkg::PH_ARM, swsft_pkg::PH_HIGH, swsft_pkg::PH_MEAS: begin
                    n_wait = w_wait_inc;
                    if (r_phase == swsft_pkg::PH_ARM) begin
                        if (!i_head.line) begin
                            n_phase = swsft_pkg::PH_HIGH;
                        end
                    end else if (r_phase == swsft_pkg::PH_HIGH) begin
                        if (i_head.line) begin
                            n_phase = swsft_pkg::PH_MEAS;
                            n_pw    = CW'(1);
                        end
                    end else begin
                        if (i_head.line) begin
                            n_pw = inc(r_pw);
                        end else begin
                            w_resolve = 1'b1;
                            w_bitval  = (WW'(r_pw) > WW'(r_one_thresh));
                        end
                    end
                    // a pulse that ends on the timeout tick still counts
                    if (!w_resolve && (w_wait_inc >= w_to_lim)) begin
                        w_resolve = 1'b1;
                        w_bitval  = 1'b0;
                    end
                    if (w_resolve) begin
                        w_shift_new = r_shift | ({7'd0, w_bitval} << r_bit[2:0]);
                        n_shift     = w_shift_new;
                        if (r_bit == swsft_pkg::REPLY_LAST) begin
                            w_res.reply_valid = 1'b1;
                            w_res.reply_byte  = w_shift_new;
                            n_bit             = '0;
                            n_tick            = '0;
                            n_phase = (w_gap_lim == '0) ? swsft_pkg::PH_IDLE
                                                        : swsft_pkg::PH_GAP;
                        end else begin
                            n_bit   = r_bit + 4'd1;
                            n_wait  = '0;
                            n_pw    = '0;
                            n_phase = swsft_pkg::PH_ARM;
                        end
                    end
                end
                swsft_pkg::PH_GAP: begin
                    n_tick = w_tick_inc;
                    if (w_tick_inc >= w_gap_lim) begin
                        n_phase = swsft_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = swsft_pkg::PH_IDLE;
                end
            endcase
        end

        if (w_enter_rx) begin
            n_tick  = '0;
            n_bit   = '0;
            n_shift = '0;
            n_wait  = '0;
            n_pw    = '0;
            n_phase = swsft_pkg::PH_ARM;
        end

        w_res.busy_res = (n_phase != swsft_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= swsft_pkg::PH_IDLE;
            r_byte  <= '0;
            r_bit   <= '0;
            r_tick  <= '0;
            r_pw    <= '0;
            r_wait  <= '0;
            r_shift <= '0;
        end else if (w_pop) begin
            r_phase <= n_phase;
            r_byte  <= n_byte;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_pw    <= n_pw;
            r_wait  <= n_wait;
            r_shift <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_load) begin
            r_frame <= w_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks  <= swsft_pkg::RST_BIT_TICKS;
            r_one_thresh <= swsft_pkg::RST_ONE_THRESH;
            r_timeout    <= swsft_pkg::RST_TIMEOUT;
            r_turnaround <= swsft_pkg::RST_TURNAROUND;
            r_gap        <= swsft_pkg::RST_GAP;
        end else if (i_cfg_we) begin
            case (swsft_pkg::t_cfg_idx'(i_cfg_idx))
                swsft_pkg::CFG_BIT_TICKS:  r_bit_ticks  <= i_cfg_data;
                swsft_pkg::CFG_ONE_THRESH: r_one_thresh <= i_cfg_data;
                swsft_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                swsft_pkg::CFG_TURNAROUND: r_turnaround <= i_cfg_data;
                swsft_pkg::CFG_GAP:        r_gap        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // output register: hold the result until the sink takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_pop) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_res <= w_res;
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.line_out    = r_res.line_out;
    assign o_rsp.line_drive  = r_res.line_drive;
    assign o_rsp.busy_res    = r_res.busy_res;
    assign o_rsp.reply_valid = r_res.reply_valid;
    assign o_rsp.reply_byte  = r_res.reply_byte;

    `SWSFT_ASSERT_IMPL(a_level_needs_drive, i_clk, i_rst_n, r_ovalid && r_res.line_out, r_res.line_drive)
    `SWSFT_ASSERT_NEXT(a_start_enters_tx, i_clk, i_rst_n, w_pop && w_load, r_phase == swsft_pkg::PH_TX)
    `SWSFT_ASSERT_NEXT(a_reply_ends_rx, i_clk, i_rst_n, w_pop && w_res.reply_valid, r_phase == swsft_pkg::PH_GAP || r_phase == swsft_pkg::PH_IDLE)
    `SWSFT_ASSERT_IMPL(a_tx_bit_range, i_clk, i_rst_n, r_phase == swsft_pkg::PH_TX, r_bit <= swsft_pkg::LAST_BIT)

endmodule

[sv/single_wire_servo_frame_transceiver.sv]
// Top level of the single-wire servo frame transceiver
//
//  channel   direction  handshake               payload
//  i_req     in         valid / ready           kind, data0..data3, position, line_in
//  o_rsp     out        valid / ready           line_out, line_drive, busy_res,
//                                               reply_valid, reply_byte
//  i_cfg_*   in         write enable, no wait   register index, 16-bit value
//
//  One beat a cycle in and one result a cycle out while the sink takes every result; each
//  result is offered once its beat has passed the queue slot and the sequencer has written
//  it into the output register.
//  The sequencer steps its whole state once per beat, so every tick counts one beat.
//  A two-entry queue sits between the front end and the sequencer; the sequencer stalls
//  while the queue is empty or the output register holds a result the sink has not taken.
//  Synchronous active-low reset; no clearing pass, the block takes beats straight away.
`timescale 1ns / 1ps

module single_wire_servo_frame_transceiver #(
    parameter int COUNT_WIDTH = 16,
    parameter int DATA_BYTES  = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    swsft_in_if.sink                         i_req,
    swsft_out_if.source                      o_rsp,
    input  logic                             i_cfg_we,
    input  logic [swsft_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swsft_pkg::CFG_W-1:0]      i_cfg_data
);

    swsft_pkg::t_item w_head;
    logic             w_head_valid;
    logic             w_pop;

    swsft_front #(
        .DATA_BYTES (DATA_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid)
    );

    swsft_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DATA_BYTES  (DATA_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_rsp        (o_rsp)
    );

endmodule
